// File: hw/rtl/kwm_pkg.sv
package kwm_pkg;

   // Default sizes of the merge engine.
   localparam int NUM_LISTS_DEF   = 8;
   localparam int LIST_DEPTH_DEF  = 256;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths of the request and response channels.
   localparam int TYPE_WIDTH = 2;
   localparam int IDX_WIDTH  = 3;

   // Request codes. The fourth code is unused and ignored.
   typedef enum logic [TYPE_WIDTH-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic clear_en;
      logic scan_init;
      logic scan_step;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
   } sts_type;

endpackage

// File: hw/rtl/kwm_ram.sv
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/kwm_ctrl.sv
module kwm_ctrl
   import kwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [TYPE_WIDTH-1:0] req_type,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cmd_type               cmd,
   input  sts_type               sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_type == REQ_LOAD) begin
                  cmd.load_en = 1'b1;
               end else if (req_type == REQ_CLEAR) begin
                  cmd.clear_en = 1'b1;
               end else if (req_type == REQ_POP) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A result never overwrites one that is still waiting.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over a pending response");

   // An accepted pop always starts a scan.
   a_pop_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_POP)) |=> (state_ff == ST_SCAN))
      else $error("pop request did not start a scan");

   // The response only turns valid through a commit.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("response valid without a commit");

endmodule

// File: hw/rtl/kwm_dpath.sv
module kwm_dpath
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS   = NUM_LISTS_DEF,
   parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   input  logic [IDX_WIDTH-1:0]          req_list_index,
   input  logic signed [VALUE_WIDTH-1:0] req_element_value,
   output logic signed [VALUE_WIDTH-1:0] rsp_merged_value,
   output logic [IDX_WIDTH-1:0]          rsp_source_list,
   output logic                          rsp_all_empty
);

   localparam int LW    = $clog2(NUM_LISTS);
   localparam int PW    = $clog2(LIST_DEPTH);
   localparam int CW    = $clog2(LIST_DEPTH + 1);
   localparam int DEPTH = NUM_LISTS << PW;
   localparam int AW    = LW + PW;

   localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   logic [CW-1:0] fill_ff [NUM_LISTS];
   logic [CW-1:0] fill_in [NUM_LISTS];
   logic [CW-1:0] rp_ff   [NUM_LISTS];
   logic [CW-1:0] rp_in   [NUM_LISTS];

   logic [LW-1:0]          cnt_ff, cnt_in;
   logic                   hit_ff, hit_in;
   logic [LW-1:0]          hit_idx_ff, hit_idx_in;
   logic [VALUE_WIDTH-1:0] best_ff, best_in;
   logic [LW-1:0]          best_list_ff, best_list_in;
   logic                   found_ff, found_in;
   logic [VALUE_WIDTH-1:0] out_value_ff, out_value_in;
   logic [IDX_WIDTH-1:0]   out_src_ff, out_src_in;
   logic                   out_empty_ff, out_empty_in;

   logic [LW-1:0]          ld_idx;
   logic                   ld_in_range;
   logic                   ld_ok;
   logic                   head_present;
   logic                   take_head;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   assign ld_idx      = LW'(req_list_index);
   assign ld_in_range = 32'(req_list_index) < 32'(NUM_LISTS);
   assign ld_ok       = cmd.load_en && ld_in_range && (fill_ff[ld_idx] < CW'(LIST_DEPTH));
   assign wr_addr     = {ld_idx, fill_ff[ld_idx][PW-1:0]};

   assign head_present = rp_ff[cnt_ff] < fill_ff[cnt_ff];
   assign rd_addr      = {cnt_ff, rp_ff[cnt_ff][PW-1:0]};

   // Equal heads go to the later list, so the compare is less than or equal.
   assign take_head = hit_ff && ($signed(rd_data) <= $signed(best_ff));

   assign sts.scan_last = (cnt_ff == LW'(NUM_LISTS - 1));

   kwm_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ld_ok),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (cmd.scan_step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         fill_in[i] = fill_ff[i];
         rp_in[i]   = rp_ff[i];
         if (cmd.clear_en) begin
            fill_in[i] = '0;
            rp_in[i]   = '0;
         end else begin
            if (ld_ok && (ld_idx == LW'(i))) begin
               fill_in[i] = fill_ff[i] + 1'b1;
            end
            if (cmd.commit && found_ff && (best_list_ff == LW'(i))) begin
               rp_in[i] = rp_ff[i] + 1'b1;
            end
         end
      end

      cnt_in       = cnt_ff;
      hit_in       = cmd.scan_step && head_present;
      hit_idx_in   = cnt_ff;
      best_in      = best_ff;
      best_list_in = best_list_ff;
      found_in     = found_ff;
      if (cmd.scan_init) begin
         cnt_in       = '0;
         best_in      = VAL_MAX;
         best_list_in = '0;
         found_in     = 1'b0;
      end else begin
         if (cmd.scan_step) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (take_head) begin
            best_in      = rd_data;
            best_list_in = hit_idx_ff;
            found_in     = 1'b1;
         end
      end

      out_value_in = out_value_ff;
      out_src_in   = out_src_ff;
      out_empty_in = out_empty_ff;
      if (cmd.commit) begin
         out_value_in = best_ff;
         out_src_in   = IDX_WIDTH'(best_list_ff);
         out_empty_in = !found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            fill_ff[i] <= '0;
            rp_ff[i]   <= '0;
         end
         cnt_ff   <= '0;
         hit_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            fill_ff[i] <= fill_in[i];
            rp_ff[i]   <= rp_in[i];
         end
         cnt_ff   <= cnt_in;
         hit_ff   <= hit_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      best_ff      <= best_in;
      best_list_ff <= best_list_in;
      out_value_ff <= out_value_in;
      out_src_ff   <= out_src_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_merged_value = out_value_ff;
   assign rsp_source_list  = out_src_ff;
   assign rsp_all_empty    = out_empty_ff;

   // The list that wins a pop must still hold an unread element.
   a_winner_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && found_ff) |-> (rp_ff[best_list_ff] < fill_ff[best_list_ff]))
      else $error("popped list had no unread element");

endmodule

// File: hw/rtl/kway_merge_engine_unit.sv
// Channel   Ports                                           Direction
// request   req_valid req_ready req_type req_list_index     in
//           req_element_value
// response  rsp_valid rsp_ready rsp_merged_value            out
//           rsp_source_list rsp_all_empty
//
// A load or clear request is done in the idle state and the block is ready again at once.
// A pop steps through accept, one element store read per list, the last compare
// and a commit into the response register; the list heads are fetched one per
// cycle through the single read port of the store.
// Reset is synchronous and active high and empties every list at once.
// A waiting response blocks only a pop, which holds in its commit cycle.
module kway_merge_engine_unit
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS   = NUM_LISTS_DEF,
   parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [TYPE_WIDTH-1:0]         req_type,
   input  logic [IDX_WIDTH-1:0]          req_list_index,
   input  logic signed [VALUE_WIDTH-1:0] req_element_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_merged_value,
   output logic [IDX_WIDTH-1:0]          rsp_source_list,
   output logic                          rsp_all_empty
);

   // The controller sequences each request; the datapath holds the list
   // counters, the element store, the running minimum and the response data.
   cmd_type cmd;
   sts_type sts;

   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   kwm_dpath #(
      .NUM_LISTS   (NUM_LISTS),
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_list_index    (req_list_index),
      .req_element_value (req_element_value),
      .rsp_merged_value  (rsp_merged_value),
      .rsp_source_list   (rsp_source_list),
      .rsp_all_empty     (rsp_all_empty)
   );

endmodule

// File: tb/sv/kway_merge_engine_unit_tb.sv
module kway_merge_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kwm_pkg::*;

   localparam int NL    = NUM_LISTS_DEF;
   localparam int DEPTH = LIST_DEPTH_DEF;
   localparam int VW    = VALUE_WIDTH_DEF;

   // Request code 3 has no member in the package enum; the block must ignore it.
   localparam logic [TYPE_WIDTH-1:0] REQ_UNUSED = 2'd3;

   localparam int RESET_CYCLES   = 7;
   localparam int HOLD_CYCLES    = 400;
   localparam int END_CYCLES     = 3 * (NL + 3);
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_REQUESTS = 95;

   typedef logic signed [VW-1:0] value_type;

   localparam value_type VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam value_type VAL_MIN = {1'b1, {(VW-1){1'b0}}};

   // One predicted pop response.
   typedef struct {
      value_type            value;
      logic [IDX_WIDTH-1:0] list;
      logic                 empty;
   } merge_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TYPE_WIDTH-1:0] req_type = REQ_LOAD;
   logic [IDX_WIDTH-1:0]  req_list_index = '0;
   value_type             req_element_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   value_type             rsp_merged_value;
   logic [IDX_WIDTH-1:0]  rsp_source_list;
   logic                  rsp_all_empty;

   // Predictor state: the contents of every list, how many values each holds
   // and how many of them have been popped.
   value_type list_store [NL][DEPTH];
   int        list_fill  [NL] = '{default: 0};
   int        list_rdpos [NL] = '{default: 0};

   // Pop responses predicted but not yet seen, oldest first.
   merge_result_type expected_merges[$];

   // Tail value of each list in the current round, used to keep loads sorted.
   value_type round_tail [NL] = '{default: '0};

   int error_count   = 0;
   int requests_sent = 0;
   int idle_cycles   = 0;

   // Idling controls. The sender percentage is only read by the stimulus
   // process; the receiver percentage and the hold-off request are written with
   // nonblocking assignments so the response process sees them race free.
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int hold_request  = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   kway_merge_engine_unit #(
      .NUM_LISTS   (NL),
      .LIST_DEPTH  (DEPTH),
      .VALUE_WIDTH (VW)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_list_index    (req_list_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_merged_value  (rsp_merged_value),
      .rsp_source_list   (rsp_source_list),
      .rsp_all_empty     (rsp_all_empty)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (error_count < 40) begin
         $display("MISMATCH at %0t ns: %s", $realtime, what);
      end
      error_count++;
   endtask

   // Applies one accepted request to the predicted state. A pop scans every
   // list in order and keeps the smallest head; comparing with less-or-equal
   // lets a higher-numbered list win a tie. When no list has an unread value
   // the response carries the largest signed value and the empty flag.
   function automatic void model_request(input logic [TYPE_WIDTH-1:0] code,
                                         input logic [IDX_WIDTH-1:0]  idx,
                                         input value_type             val);
      merge_result_type res;
      value_type        best;
      int               best_list;
      bit               found;
      case (code)
         REQ_LOAD: begin
            if (int'(idx) < NL && list_fill[idx] < DEPTH) begin
               list_store[idx][list_fill[idx]] = val;
               list_fill[idx]++;
            end
         end
         REQ_CLEAR: begin
            for (int i = 0; i < NL; i++) begin
               list_fill[i]  = 0;
               list_rdpos[i] = 0;
            end
         end
         REQ_POP: begin
            best      = VAL_MAX;
            best_list = 0;
            found     = 1'b0;
            for (int i = 0; i < NL; i++) begin
               if (list_rdpos[i] < list_fill[i] && list_store[i][list_rdpos[i]] <= best) begin
                  best      = list_store[i][list_rdpos[i]];
                  best_list = i;
                  found     = 1'b1;
               end
            end
            if (found) begin
               list_rdpos[best_list]++;
            end
            res.value = best;
            res.list  = found ? best_list[IDX_WIDTH-1:0] : '0;
            res.empty = !found;
            expected_merges.push_back(res);
         end
         default: begin
         end
      endcase
   endfunction

   // Offers one request, idling first at the current sender rate, and waits
   // for the handshake. Valid stays high after acceptance so that the next
   // request can follow back to back; only an idle cycle or a drain lowers it.
   task automatic send_request(input logic [TYPE_WIDTH-1:0] code,
                               input logic [IDX_WIDTH-1:0]  idx,
                               input value_type             val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= code;
      req_list_index    <= idx;
      req_element_value <= val;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      model_request(code, idx, val);
      if (code != REQ_UNUSED) begin
         requests_sent++;
      end
   endtask

   // Stops offering requests until every predicted response has arrived.
   task automatic wait_for_merges_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_merges.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_idling(input int send_pct, input int rcv_pct);
      send_idle_pct = send_pct;
      rcv_stall_pct <= rcv_pct;
   endtask

   function automatic value_type random_value();
      return value_type'($urandom);
   endfunction

   // Start value of a sorted list: anywhere, or near one of the extremes or zero.
   function automatic value_type random_start();
      case ($urandom_range(3))
         0: return random_value();
         1: return VAL_MIN + value_type'($urandom_range(0, 3));
         2: return VAL_MAX - value_type'($urandom_range(0, 40));
         default: return value_type'($urandom_range(0, 20)) - value_type'(10);
      endcase
   endfunction

   // Next value of a sorted list. Zero steps create ties between lists, and the
   // sum saturates at the largest signed value.
   function automatic value_type next_sorted(input int l);
      longint nv;
      if ($urandom_range(2) == 0) begin
         nv = longint'(round_tail[l]);
      end else begin
         nv = longint'(round_tail[l]) + longint'($urandom_range(1, 1 << $urandom_range(0, 30)));
      end
      if (nv > longint'(VAL_MAX)) begin
         nv = longint'(VAL_MAX);
      end
      round_tail[l] = value_type'(nv);
      return round_tail[l];
   endfunction

   // Response side: checks each accepted response against the oldest
   // prediction and then decides rsp_ready for the next cycle, either from
   // the stall rate or from a pending long hold-off.
   always @(posedge clock) begin
      merge_result_type exp_res;
      if (rsp_valid && rsp_ready) begin
         if (expected_merges.size() == 0) begin
            report_mismatch($sformatf("response with no pop pending: value %0d list %0d empty %0b",
                                      rsp_merged_value, rsp_source_list, rsp_all_empty));
         end else begin
            exp_res = expected_merges.pop_front();
            if (rsp_merged_value !== exp_res.value) begin
               report_mismatch($sformatf("merged_value %0d, expected %0d",
                                         rsp_merged_value, exp_res.value));
            end
            if (rsp_source_list !== exp_res.list) begin
               report_mismatch($sformatf("source_list %0d, expected %0d",
                                         rsp_source_list, exp_res.list));
            end
            if (rsp_all_empty !== exp_res.empty) begin
               report_mismatch($sformatf("all_empty %0b, expected %0b",
                                         rsp_all_empty, exp_res.empty));
            end
         end
      end
      if (hold_seen != hold_request) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // Watchdog: ends the run when no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Extremes of the value field, both list indexes at the ends, ties, a real
   // element equal to the largest signed value, the unused request code, pops
   // with every list used up, and loads after a clear.
   task automatic test_directed();
      set_idling(0, 0);
      send_request(REQ_POP, 3'd0, '0);
      send_request(REQ_LOAD, 3'd0, VAL_MIN);
      send_request(REQ_LOAD, 3'd7, VAL_MAX);
      send_request(REQ_LOAD, 3'd3, -1);
      send_request(REQ_LOAD, 3'd3, 0);
      send_request(REQ_LOAD, 3'd5, -1);
      send_request(REQ_UNUSED, 3'd1, 5);
      repeat (6) send_request(REQ_POP, 3'd0, '0);
      send_request(REQ_LOAD, 3'd2, VAL_MAX);
      send_request(REQ_LOAD, 3'd6, VAL_MAX);
      repeat (3) send_request(REQ_POP, 3'd7, VAL_MAX);
      send_request(REQ_LOAD, 3'd1, 32'sh5555_5555);
      send_request(REQ_LOAD, 3'd4, 32'shAAAA_AAAA);
      send_request(REQ_CLEAR, 3'd4, VAL_MIN);
      send_request(REQ_POP, 3'd0, '0);
      send_request(REQ_LOAD, 3'd4, 7);
      send_request(REQ_POP, 3'd0, '0);
      wait_for_merges_drained();
   endtask

   // Fills one list past its depth so the last loads are dropped, then reads
   // everything back, ending with a pop that finds all lists empty.
   task automatic test_list_overflow();
      set_idling(15, 15);
      send_request(REQ_CLEAR, 3'd0, '0);
      round_tail[5] = random_start();
      round_tail[1] = random_start();
      for (int k = 0; k < DEPTH + 2; k++) begin
         send_request(REQ_LOAD, 3'd5, next_sorted(5));
      end
      repeat (3) send_request(REQ_LOAD, 3'd1, next_sorted(1));
      repeat (DEPTH + 4) send_request(REQ_POP, 3'(($urandom)), random_value());
      wait_for_merges_drained();
   endtask

   // The receiver holds off for a long stretch while pops keep coming, so the
   // response register fills and the block stops taking requests.
   task automatic test_backpressure();
      set_idling(0, 0);
      send_request(REQ_CLEAR, 3'd0, '0);
      for (int l = 0; l < NL; l++) begin
         round_tail[l] = random_start();
      end
      repeat (12) begin
         int l;
         l = $urandom_range(NL - 1);
         send_request(REQ_LOAD, l[IDX_WIDTH-1:0], next_sorted(l));
      end
      hold_request <= hold_request + 1;
      repeat (12) send_request(REQ_POP, '0, '0);
      wait_for_merges_drained();
   endtask

   // One merge round: mostly sorted loads spread over random lists with a few
   // pops in between, some noise, then enough pops to use every list up.
   task automatic run_merge_round(input int max_len);
      int total;
      int r;
      int l;
      int remaining;
      if ($urandom_range(9) != 0) begin
         send_request(REQ_CLEAR, 3'($urandom), random_value());
      end
      for (int i = 0; i < NL; i++) begin
         round_tail[i] = random_start();
      end
      total = $urandom_range(1, max_len);
      for (int k = 0; k < total; k++) begin
         r = $urandom_range(99);
         l = $urandom_range(NL - 1);
         if (r < 4) begin
            send_request(REQ_UNUSED, l[IDX_WIDTH-1:0], random_value());
         end else if (r < 8) begin
            send_request(REQ_LOAD, l[IDX_WIDTH-1:0], random_value());
         end else if (r < 25) begin
            send_request(REQ_POP, l[IDX_WIDTH-1:0], random_value());
         end else begin
            send_request(REQ_LOAD, l[IDX_WIDTH-1:0], next_sorted(l));
         end
      end
      remaining = 0;
      for (int i = 0; i < NL; i++) begin
         remaining += list_fill[i] - list_rdpos[i];
      end
      repeat (remaining + $urandom_range(0, 2)) begin
         send_request(REQ_POP, 3'($urandom), random_value());
      end
   endtask

   task automatic test_merge_phase(input int send_pct, input int rcv_pct);
      int start;
      set_idling(send_pct, rcv_pct);
      start = requests_sent;
      while (requests_sent - start < PHASE_REQUESTS) begin
         run_merge_round(($urandom_range(4) == 0) ? 50 : 16);
      end
      wait_for_merges_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_list_overflow();
      test_backpressure();
      test_merge_phase(0, 0);
      test_merge_phase(60, 0);
      test_merge_phase(0, 60);
      test_merge_phase(15, 15);

      // Let any stray response show up before the verdict.
      wait_for_merges_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_merges.size() != 0) begin
         report_mismatch($sformatf("%0d pop responses never arrived", expected_merges.size()));
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
